// File: hdl/ffbta_pkg.sv
// package for the first-fit boundary-tag allocator core
// holds heap geometry, tag layout, state and code types; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ffbta_pkg;

   localparam int HEAP_BYTES = 4096;
   localparam int WORD_BYTES = 8;
   localparam int NWORDS     = HEAP_BYTES / WORD_BYTES;
   localparam int DBL_BYTES  = 2 * WORD_BYTES;

   localparam int IDX_W  = $clog2(NWORDS);
   localparam int HIDX_W = IDX_W + 1;
   localparam int SHIFT  = $clog2(WORD_BYTES);
   localparam int TAG_W  = $clog2(HEAP_BYTES) + 1;

   localparam int ADDR_W = 12;
   localparam int SIZE_W = 12;
   localparam int STAT_W = 2;
   localparam int ASZ_W  = ((TAG_W > SIZE_W) ? TAG_W : SIZE_W) + 2;
   localparam int CMP_W  = (TAG_W > ADDR_W) ? TAG_W : ADDR_W;

   localparam logic [TAG_W-1:0] DELIM_TAG = TAG_W'(1);
   localparam logic [TAG_W-1:0] FREE_TAG  = TAG_W'(HEAP_BYTES - DBL_BYTES);

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FAIL    = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_INIT,
      FSM_IDLE,
      FSM_READ,
      FSM_EVAL,
      FSM_NEXT_READ,
      FSM_NEXT_EVAL,
      FSM_WRITE
   } fsm_type;

endpackage

`default_nettype wire

// File: hdl/first_fit_boundary_tag_allocator_core.sv
// first-fit boundary-tag heap allocator: tag memory, block walker and tag writer
// depends on ffbta_pkg
//
// usage: drive req_action, req_request_size and req_block_address with start high;
// the word is taken at a clock edge where start is high and busy is low.
// allocate (action 0) walks the block headers from the heap start, one header at a
// time through the tag memory read port, and takes the first free block that fits,
// splitting it when at least two words would remain. free (action 1) walks to the
// block, reads the following header and merges with free neighbors.
// each request yields exactly one result word on rsp_result_address / rsp_status,
// marked by rsp_valid for one cycle; the receiver cannot stall it.
// an allocate of size zero or a free of address zero is answered from idle with no
// walk. an allocate fails when no free block fits; a free is ignored when its
// address is not that of an allocated block.
// the response waits on the header walk through the one memory read port and on
// the tag writes through the one write port. busy stays high until the result for
// every request that starts a walk.
// after reset, busy is high while the delimiters and the initial free
// block tags are written.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_boundary_tag_allocator_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_action,
   input  wire logic [ffbta_pkg::SIZE_W-1:0] req_request_size,
   input  wire logic [ffbta_pkg::ADDR_W-1:0] req_block_address,
   output logic                              rsp_valid,
   output logic [ffbta_pkg::ADDR_W-1:0]      rsp_result_address,
   output logic [ffbta_pkg::STAT_W-1:0]      rsp_status
);

   localparam int TAG_W  = ffbta_pkg::TAG_W;
   localparam int IDX_W  = ffbta_pkg::IDX_W;
   localparam int HIDX_W = ffbta_pkg::HIDX_W;
   localparam int SHIFT  = ffbta_pkg::SHIFT;
   localparam int ASZ_W  = ffbta_pkg::ASZ_W;
   localparam int ADDR_W = ffbta_pkg::ADDR_W;
   localparam int CMP_W  = ffbta_pkg::CMP_W;
   localparam logic [HIDX_W-1:0] NWORDS_H = HIDX_W'(ffbta_pkg::NWORDS);

   // tag memory
   logic [TAG_W-1:0] mem [ffbta_pkg::NWORDS];
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [IDX_W-1:0] mem_ra;
   logic [TAG_W-1:0] mem_wd;
   logic [TAG_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   // control state
   ffbta_pkg::fsm_type    state_ff, state_in;
   logic [1:0]            wstep_ff, wstep_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload state
   logic                  action_ff, action_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [ASZ_W-1:0]      asize_ff, asize_in;
   logic [HIDX_W-1:0]     h_ff, h_in;
   logic [TAG_W-1:0]      csize_ff, csize_in;
   logic [HIDX_W-1:0]     nidx_ff, nidx_in;
   logic                  prev_free_ff, prev_free_in;
   logic [HIDX_W-1:0]     prev_h_ff, prev_h_in;
   logic [TAG_W-1:0]      prev_size_ff, prev_size_in;
   logic [HIDX_W-1:0]     a_base_ff, a_base_in;
   logic [TAG_W-1:0]      a_size_ff, a_size_in;
   logic                  a_alloc_ff, a_alloc_in;
   logic [HIDX_W-1:0]     b_base_ff, b_base_in;
   logic [TAG_W-1:0]      b_size_ff, b_size_in;
   logic                  two_ff, two_in;
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [ffbta_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffbta_pkg::FSM_INIT;
         wstep_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wstep_ff     <= wstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      addr_ff       <= addr_in;
      asize_ff      <= asize_in;
      h_ff          <= h_in;
      csize_ff      <= csize_in;
      nidx_ff       <= nidx_in;
      prev_free_ff  <= prev_free_in;
      prev_h_ff     <= prev_h_in;
      prev_size_ff  <= prev_size_in;
      a_base_ff     <= a_base_in;
      a_size_ff     <= a_size_in;
      a_alloc_ff    <= a_alloc_in;
      b_base_ff     <= b_base_in;
      b_size_ff     <= b_size_in;
      two_ff        <= two_in;
      res_addr_ff   <= res_addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // decoded tag from the read port, with walk, merge and write helpers
   logic [HIDX_W-1:0] t_words;
   logic [TAG_W-1:0]  t_size;
   logic              t_alloc;
   logic [HIDX_W-1:0] h_next;
   logic [CMP_W-1:0]  pay_addr;
   logic [ASZ_W-1:0]  asize_raw;
   logic [TAG_W-1:0]  nt;
   logic [TAG_W-1:0]  n_size;
   logic [TAG_W-1:0]  merged;
   logic [HIDX_W-1:0] w_base;
   logic [TAG_W-1:0]  w_size;
   logic              w_alloc;
   logic [HIDX_W-1:0] w_idx;
   logic              w_last;

   always_comb begin
      t_words   = rdata_ff[TAG_W-1:SHIFT];
      t_size    = {rdata_ff[TAG_W-1:SHIFT], SHIFT'(0)};
      t_alloc   = rdata_ff[0];
      h_next    = h_ff + t_words;
      pay_addr  = CMP_W'((CMP_W'(h_ff) + CMP_W'(1)) << SHIFT);
      asize_raw = ASZ_W'(req_request_size) + ASZ_W'(ffbta_pkg::DBL_BYTES)
                + ASZ_W'(ffbta_pkg::WORD_BYTES - 1);
      nt        = (nidx_ff < NWORDS_H) ? rdata_ff : ffbta_pkg::DELIM_TAG;
      n_size    = {nt[TAG_W-1:SHIFT], SHIFT'(0)};
      merged    = csize_ff
                + ((n_size != '0 && !nt[0]) ? n_size : '0)
                + (prev_free_ff ? prev_size_ff : '0);
      w_base    = wstep_ff[1] ? b_base_ff : a_base_ff;
      w_size    = wstep_ff[1] ? b_size_ff : a_size_ff;
      w_alloc   = wstep_ff[1] ? 1'b0 : a_alloc_ff;
      w_idx     = wstep_ff[0] ? (w_base + w_size[TAG_W-1:SHIFT] - HIDX_W'(1)) : w_base;
      w_last    = wstep_ff[0] && (wstep_ff[1] || !two_ff);

      state_in      = state_ff;
      wstep_in      = wstep_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      action_in     = action_ff;
      addr_in       = addr_ff;
      asize_in      = asize_ff;
      h_in          = h_ff;
      csize_in      = csize_ff;
      nidx_in       = nidx_ff;
      prev_free_in  = prev_free_ff;
      prev_h_in     = prev_h_ff;
      prev_size_in  = prev_size_ff;
      a_base_in     = a_base_ff;
      a_size_in     = a_size_ff;
      a_alloc_in    = a_alloc_ff;
      b_base_in     = b_base_ff;
      b_size_in     = b_size_ff;
      two_in        = two_ff;
      res_addr_in   = res_addr_ff;
      mem_we        = 1'b0;
      mem_wa        = w_idx[IDX_W-1:0];
      mem_wd        = w_size | TAG_W'(w_alloc);
      mem_ra        = h_ff[IDX_W-1:0];

      case (state_ff)
         ffbta_pkg::FSM_INIT: begin
            mem_we   = 1'b1;
            wstep_in = wstep_ff + 2'd1;
            case (wstep_ff)
               2'd0: begin
                  mem_wa = IDX_W'(0);
                  mem_wd = ffbta_pkg::DELIM_TAG;
               end
               2'd1: begin
                  mem_wa = IDX_W'(1);
                  mem_wd = ffbta_pkg::FREE_TAG;
               end
               2'd2: begin
                  mem_wa = IDX_W'(ffbta_pkg::NWORDS - 2);
                  mem_wd = ffbta_pkg::FREE_TAG;
               end
               default: begin
                  mem_wa   = IDX_W'(ffbta_pkg::NWORDS - 1);
                  mem_wd   = ffbta_pkg::DELIM_TAG;
                  state_in = ffbta_pkg::FSM_IDLE;
               end
            endcase
         end

         ffbta_pkg::FSM_IDLE: begin
            if (start) begin
               action_in    = req_action;
               addr_in      = req_block_address;
               asize_in     = {asize_raw[ASZ_W-1:SHIFT], SHIFT'(0)};
               h_in         = HIDX_W'(1);
               prev_free_in = 1'b0;
               prev_h_in    = '0;
               prev_size_in = '0;
               if (req_action == ffbta_pkg::ACTION_ALLOC && req_request_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffbta_pkg::STATUS_FAIL;
               end else if (req_action == ffbta_pkg::ACTION_FREE
                            && req_block_address == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffbta_pkg::STATUS_IGNORED;
               end else begin
                  state_in = ffbta_pkg::FSM_READ;
               end
            end
         end

         ffbta_pkg::FSM_READ: begin
            state_in = ffbta_pkg::FSM_EVAL;
         end

         ffbta_pkg::FSM_EVAL: begin
            if (t_words == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = (action_ff == ffbta_pkg::ACTION_ALLOC)
                             ? ffbta_pkg::STATUS_FAIL : ffbta_pkg::STATUS_IGNORED;
               state_in      = ffbta_pkg::FSM_IDLE;
            end else if (action_ff == ffbta_pkg::ACTION_ALLOC
                         && !t_alloc && ASZ_W'(t_size) >= asize_ff) begin
               // first fit found
               a_base_in   = h_ff;
               a_alloc_in  = 1'b1;
               b_base_in   = h_ff + HIDX_W'(asize_ff >> SHIFT);
               b_size_in   = t_size - TAG_W'(asize_ff);
               res_addr_in = pay_addr[ADDR_W-1:0];
               wstep_in    = 2'd0;
               state_in    = ffbta_pkg::FSM_WRITE;
               if (ASZ_W'(t_size) - asize_ff >= ASZ_W'(ffbta_pkg::DBL_BYTES)) begin
                  a_size_in = TAG_W'(asize_ff);
                  two_in    = 1'b1;
               end else begin
                  a_size_in = t_size;
                  two_in    = 1'b0;
               end
            end else if (action_ff == ffbta_pkg::ACTION_FREE
                         && pay_addr == CMP_W'(addr_ff)) begin
               if (t_alloc) begin
                  csize_in = t_size;
                  nidx_in  = h_next;
                  state_in = ffbta_pkg::FSM_NEXT_READ;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffbta_pkg::STATUS_IGNORED;
                  state_in      = ffbta_pkg::FSM_IDLE;
               end
            end else begin
               prev_free_in = !t_alloc;
               prev_h_in    = h_ff;
               prev_size_in = t_size;
               h_in         = h_next;
               if (h_next < NWORDS_H) begin
                  state_in = ffbta_pkg::FSM_READ;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = (action_ff == ffbta_pkg::ACTION_ALLOC)
                                ? ffbta_pkg::STATUS_FAIL : ffbta_pkg::STATUS_IGNORED;
                  state_in      = ffbta_pkg::FSM_IDLE;
               end
            end
         end

         ffbta_pkg::FSM_NEXT_READ: begin
            mem_ra   = nidx_ff[IDX_W-1:0];
            state_in = ffbta_pkg::FSM_NEXT_EVAL;
         end

         ffbta_pkg::FSM_NEXT_EVAL: begin
            // merge with free neighbors
            a_base_in   = prev_free_ff ? prev_h_ff : h_ff;
            a_size_in   = merged;
            a_alloc_in  = 1'b0;
            two_in      = 1'b0;
            res_addr_in = '0;
            wstep_in    = 2'd0;
            state_in    = ffbta_pkg::FSM_WRITE;
         end

         ffbta_pkg::FSM_WRITE: begin
            mem_we = (w_idx < NWORDS_H);
            if (w_last) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = ffbta_pkg::STATUS_DONE;
               state_in      = ffbta_pkg::FSM_IDLE;
            end else begin
               wstep_in = wstep_ff + 2'd1;
            end
         end

         default: begin
            state_in = ffbta_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ffbta_pkg::FSM_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire
